FILE: hw/rtl/gn3_pkg.sv
// ----------------------------------------------------------------------------
// Gradient noise package
// Shared constants, state types and the interface structs between the
// evaluator and its gradient normalization unit.
// ----------------------------------------------------------------------------
package gn3_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int TBL_AW     = $clog2(TABLE_SIZE);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int GRAD_W  = 18;
   localparam int ROOT_W  = 24;
   localparam int QUOT_W  = 18;
   localparam int SAMP_W  = 20;
   localparam int NOISE_W = 19;

   localparam logic signed [SAMP_W-1:0] NOISE_MAX = 20'sd131072;
   localparam logic signed [SAMP_W-1:0] NOISE_MIN = -20'sd131072;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_MUL,
      ST_XOR,
      ST_GRAD,
      ST_NSTART,
      ST_NORM,
      ST_DOT,
      ST_STORE,
      ST_LMUL,
      ST_LADD,
      ST_DONE
   } gn3_state_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_SQ,
      NS_ROOT,
      NS_DSET,
      NS_DIV,
      NS_DONE
   } gn3_norm_state_type;

   typedef struct packed {
      logic             start;
      logic [2:0][7:0]  vec;
   } gn3_norm_req_type;

   typedef struct packed {
      logic                    done;
      logic [2:0][GRAD_W-1:0]  grad;
   } gn3_norm_rsp_type;

endpackage

FILE: hw/rtl/gn3_norm.sv
// ----------------------------------------------------------------------------
// Gradient normalization unit
// Scales a vector of three signed bytes to unit length in Q1.16 with a
// bit-serial square root and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module gn3_norm (
   input  logic                      clock,
   input  logic                      reset,
   input  gn3_pkg::gn3_norm_req_type req,
   output gn3_pkg::gn3_norm_rsp_type rsp
);

   gn3_pkg::gn3_norm_state_type state_ff, state_in;
   logic [2:0][7:0]                        vec_ff, vec_in;
   logic [15:0]                            n_ff, n_in;
   logic [1:0]                             k_ff, k_in;
   logic [4:0]                             it_ff, it_in;
   logic [47:0]                            rad_ff, rad_in;
   logic [25:0]                            rem_ff, rem_in;
   logic [gn3_pkg::ROOT_W-1:0]             root_ff, root_in;
   logic [40:0]                            drem_ff, drem_in;
   logic [40:0]                            ds_ff, ds_in;
   logic [gn3_pkg::QUOT_W-1:0]             q_ff, q_in;
   logic [2:0][gn3_pkg::GRAD_W-1:0]        grad_ff, grad_in;

   logic [7:0]                  cur_v;
   logic [7:0]                  mag;
   logic [15:0]                 nsum;
   logic [27:0]                 remx;
   logic [27:0]                 trial;
   logic                        qbit;
   logic [gn3_pkg::QUOT_W-1:0]  qfin;
   logic [gn3_pkg::QUOT_W-1:0]  qsat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gn3_pkg::NS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      vec_ff  <= vec_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      it_ff   <= it_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      ds_ff   <= ds_in;
      q_ff    <= q_in;
      grad_ff <= grad_in;
   end

   always_comb begin
      state_in = state_ff;
      vec_in   = vec_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      it_in    = it_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      drem_in  = drem_ff;
      ds_in    = ds_ff;
      q_in     = q_ff;
      grad_in  = grad_ff;

      unique case (k_ff)
         2'd0:    cur_v = vec_ff[0];
         2'd1:    cur_v = vec_ff[1];
         default: cur_v = vec_ff[2];
      endcase
      mag   = cur_v[7] ? (~cur_v + 8'd1) : cur_v;
      nsum  = n_ff + ({8'd0, mag} * {8'd0, mag});
      remx  = {rem_ff, rad_ff[47:46]};
      trial = {2'b00, root_ff, 2'b01};
      qbit  = (drem_ff >= ds_ff);
      qfin  = {q_ff[gn3_pkg::QUOT_W-2:0], qbit};
      qsat  = (qfin > 18'd65536) ? 18'd65536 : qfin;

      unique case (state_ff)
         gn3_pkg::NS_IDLE: begin
            if (req.start) begin
               vec_in   = req.vec;
               n_in     = '0;
               k_in     = '0;
               state_in = gn3_pkg::NS_SQ;
            end
         end
         gn3_pkg::NS_SQ: begin
            n_in = nsum;
            if (k_ff == 2'd2) begin
               if (nsum == '0) begin
                  grad_in  = '0;
                  state_in = gn3_pkg::NS_DONE;
               end else begin
                  rad_in   = {nsum, 32'd0};
                  rem_in   = '0;
                  root_in  = '0;
                  it_in    = 5'd23;
                  state_in = gn3_pkg::NS_ROOT;
               end
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         gn3_pkg::NS_ROOT: begin
            rad_in = {rad_ff[45:0], 2'b00};
            if (remx >= trial) begin
               rem_in  = 26'(remx - trial);
               root_in = {root_ff[gn3_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = remx[25:0];
               root_in = {root_ff[gn3_pkg::ROOT_W-2:0], 1'b0};
            end
            it_in = it_ff - 5'd1;
            if (it_ff == '0) begin
               k_in     = '0;
               state_in = gn3_pkg::NS_DSET;
            end
         end
         gn3_pkg::NS_DSET: begin
            drem_in  = {1'b0, mag, 32'd0} + {17'd0, 1'b0, root_ff[gn3_pkg::ROOT_W-1:1]};
            ds_in    = {root_ff, 17'd0};
            q_in     = '0;
            it_in    = 5'd17;
            state_in = gn3_pkg::NS_DIV;
         end
         gn3_pkg::NS_DIV: begin
            if (qbit) begin
               drem_in = drem_ff - ds_ff;
            end
            ds_in = {1'b0, ds_ff[40:1]};
            q_in  = qfin;
            it_in = it_ff - 5'd1;
            if (it_ff == '0) begin
               grad_in[k_ff] = cur_v[7] ? (~qsat + 18'd1) : qsat;
               if (k_ff == 2'd2) begin
                  state_in = gn3_pkg::NS_DONE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = gn3_pkg::NS_DSET;
               end
            end
         end
         gn3_pkg::NS_DONE: begin
            state_in = gn3_pkg::NS_IDLE;
         end
         default: begin
            state_in = gn3_pkg::NS_IDLE;
         end
      endcase
   end

   assign rsp.done = (state_ff == gn3_pkg::NS_DONE);
   assign rsp.grad = grad_ff;

endmodule

FILE: hw/rtl/gradient_noise_3d_eval.sv
// ----------------------------------------------------------------------------
// 3D gradient noise evaluator
// Hashes the eight lattice corners through a loaded entropy table, takes
// unit gradient dot products and blends them trilinearly.
// ----------------------------------------------------------------------------
// A write request gives no response. An evaluate request keeps the block
// busy, during which no request is taken, and gives one response; it
// returns to idle only once the response register is free. A corner whose
// three gradient bytes are all zero skips the square root and divisions.
// The gradient normalization unit runs a 24-step square root and three
// 18-step divisions one bit a cycle; the rest of each corner runs in the
// single shared multiplier and the one read port of the table. The seven
// blend steps reuse that multiplier.
// Table entries must be written before an evaluation reads them.
module gradient_noise_3d_eval (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // table_index, table_value, point_x, point_y, point_z
   input  logic [111:0] req_tdata,
   // opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // noise_value
   output logic [23:0]  rsp_tdata
);

   localparam int AW = gn3_pkg::TBL_AW;
   localparam int SW = gn3_pkg::SAMP_W;

   gn3_pkg::gn3_state_type state_ff, state_in;

   logic [7:0]  mem [gn3_pkg::TABLE_SIZE];
   logic [7:0]  rdata_ff;
   logic [AW-1:0] raddr;
   logic        mem_we;

   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  round_ff, round_in;
   logic [2:0]  corner_ff, corner_in;
   logic [2:0]  lstep_ff, lstep_in;
   logic [2:0][31:0] base_ff, base_in;
   logic [2:0][15:0] w_ff, w_in;
   logic [2:0][31:0] a_ff, a_in;
   logic [31:0] word_ff, word_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [2:0][7:0]   v_ff, v_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [7:0][SW-1:0] s_ff, s_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [gn3_pkg::NOISE_W-1:0] rsp_data_ff, rsp_data_in;

   gn3_pkg::gn3_norm_req_type norm_req;
   gn3_pkg::gn3_norm_rsp_type norm_rsp;

   logic        req_fire;
   logic [1:0]  sel_idx;
   logic [31:0] a_sel;
   logic [1:0]  nxt_idx;
   logic [31:0] hprod;
   logic [2:0]  cbit;
   logic        dbit;
   logic [15:0] dw;
   logic signed [gn3_pkg::GRAD_W-1:0] dval;
   logic signed [gn3_pkg::GRAD_W-1:0] uval;
   logic signed [31:0] mul_a, mul_b;
   logic signed [SW:0] ldiff;
   logic [15:0] lw;
   logic signed [39:0] lrnd;
   logic signed [SW-1:0] lres;
   logic signed [35:0] arnd;
   logic signed [SW-1:0] fin;

   gn3_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (norm_req),
      .rsp   (norm_rsp)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_tdata[AW-1:0]] <= req_tdata[15:8];
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gn3_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cnt_ff      <= cnt_in;
      round_ff    <= round_in;
      corner_ff   <= corner_in;
      lstep_ff    <= lstep_in;
      base_ff     <= base_in;
      w_ff        <= w_in;
      a_ff        <= a_in;
      word_ff     <= word_in;
      prod_ff     <= prod_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      round_in      = round_ff;
      corner_in     = corner_ff;
      lstep_in      = lstep_ff;
      base_in       = base_ff;
      w_in          = w_ff;
      a_in          = a_ff;
      word_in       = word_ff;
      prod_in       = prod_ff;
      v_in          = v_ff;
      acc_in        = acc_ff;
      s_in          = s_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      raddr         = '0;
      norm_req.start = 1'b0;
      norm_req.vec   = v_ff;
      req_tready    = (state_ff == gn3_pkg::ST_IDLE);
      req_fire      = req_tvalid && req_tready;

      sel_idx = (state_ff == gn3_pkg::ST_GRAD) ? cnt_ff[1:0] : round_ff;
      unique case (sel_idx)
         2'd0:    a_sel = a_ff[0];
         2'd1:    a_sel = a_ff[1];
         default: a_sel = a_ff[2];
      endcase
      nxt_idx = (round_ff == 2'd2) ? 2'd0 : round_ff + 2'd1;
      hprod   = prod_ff[31:0];
      cbit    = {corner_ff[0], corner_ff[1], corner_ff[2]};

      unique case (cnt_ff[1:0])
         2'd0: begin
            dbit = cbit[0];
            dw   = w_ff[0];
            uval = norm_rsp.grad[0];
         end
         2'd1: begin
            dbit = cbit[1];
            dw   = w_ff[1];
            uval = norm_rsp.grad[1];
         end
         default: begin
            dbit = cbit[2];
            dw   = w_ff[2];
            uval = norm_rsp.grad[2];
         end
      endcase
      dval = dbit ? (18'sd65536 - $signed({2'b00, dw})) : -$signed({2'b00, dw});

      ldiff = $signed({s_ff[1][SW-1], s_ff[1]}) - $signed({s_ff[0][SW-1], s_ff[0]});
      if (lstep_ff < 3'd4) begin
         lw = w_ff[2];
      end else if (lstep_ff < 3'd6) begin
         lw = w_ff[1];
      end else begin
         lw = w_ff[0];
      end
      lrnd = prod_ff[39:0] + 40'sd32768;
      lres = SW'($signed(s_ff[0]) + lrnd[SW+15:16]);
      arnd = acc_ff + 36'sd32768;
      fin  = $signed(s_ff[0]);

      mul_a = '0;
      mul_b = '0;

      unique case (state_ff)
         gn3_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == gn3_pkg::OP_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  base_in[0] = {{16{req_tdata[47]}}, req_tdata[47:32]};
                  base_in[1] = {{16{req_tdata[79]}}, req_tdata[79:64]};
                  base_in[2] = {{16{req_tdata[111]}}, req_tdata[111:96]};
                  w_in[0]    = req_tdata[31:16];
                  w_in[1]    = req_tdata[63:48];
                  w_in[2]    = req_tdata[95:80];
                  corner_in  = '0;
                  state_in   = gn3_pkg::ST_SETUP;
               end
            end
         end
         gn3_pkg::ST_SETUP: begin
            a_in[0]  = base_ff[0] + {31'd0, cbit[0]};
            a_in[1]  = base_ff[1] + {31'd0, cbit[1]};
            a_in[2]  = base_ff[2] + {31'd0, cbit[2]};
            round_in = '0;
            cnt_in   = '0;
            state_in = gn3_pkg::ST_LOAD;
         end
         gn3_pkg::ST_LOAD: begin
            raddr = a_sel[AW-1:0] - AW'(4) + AW'(cnt_ff[1:0]);
            if (cnt_ff != '0) begin
               word_in = {rdata_ff, word_ff[31:8]};
            end
            if (cnt_ff == 3'd4) begin
               state_in = gn3_pkg::ST_MUL;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         gn3_pkg::ST_MUL: begin
            mul_a    = $signed(a_sel);
            mul_b    = $signed(word_ff);
            prod_in  = mul_a * mul_b;
            state_in = gn3_pkg::ST_XOR;
         end
         gn3_pkg::ST_XOR: begin
            a_in[round_ff] = hprod;
            a_in[nxt_idx]  = a_ff[nxt_idx] ^ {hprod[15:0], hprod[31:16]};
            cnt_in         = '0;
            if (round_ff == 2'd2) begin
               state_in = gn3_pkg::ST_GRAD;
            end else begin
               round_in = round_ff + 2'd1;
               state_in = gn3_pkg::ST_LOAD;
            end
         end
         gn3_pkg::ST_GRAD: begin
            raddr = a_sel[AW-1:0];
            if (cnt_ff != '0) begin
               v_in = {rdata_ff, v_ff[2:1]};
            end
            if (cnt_ff == 3'd3) begin
               state_in = gn3_pkg::ST_NSTART;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         gn3_pkg::ST_NSTART: begin
            norm_req.start = 1'b1;
            state_in       = gn3_pkg::ST_NORM;
         end
         gn3_pkg::ST_NORM: begin
            if (norm_rsp.done) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = gn3_pkg::ST_DOT;
            end
         end
         gn3_pkg::ST_DOT: begin
            mul_a   = 32'(uval);
            mul_b   = 32'(dval);
            prod_in = mul_a * mul_b;
            if (cnt_ff != '0) begin
               acc_in = acc_ff + prod_ff[35:0];
            end
            if (cnt_ff == 3'd3) begin
               state_in = gn3_pkg::ST_STORE;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         gn3_pkg::ST_STORE: begin
            s_in[corner_ff] = arnd[SW+15:16];
            if (corner_ff == 3'd7) begin
               lstep_in = '0;
               state_in = gn3_pkg::ST_LMUL;
            end else begin
               corner_in = corner_ff + 3'd1;
               state_in  = gn3_pkg::ST_SETUP;
            end
         end
         gn3_pkg::ST_LMUL: begin
            mul_a    = 32'(ldiff);
            mul_b    = $signed({16'd0, lw});
            prod_in  = mul_a * mul_b;
            state_in = gn3_pkg::ST_LADD;
         end
         gn3_pkg::ST_LADD: begin
            for (int i = 0; i < 6; i++) begin
               s_in[i] = s_ff[i + 2];
            end
            s_in[3'd6 - lstep_ff] = lres;
            if (lstep_ff == 3'd6) begin
               state_in = gn3_pkg::ST_DONE;
            end else begin
               lstep_in = lstep_ff + 3'd1;
               state_in = gn3_pkg::ST_LMUL;
            end
         end
         gn3_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               if (fin > gn3_pkg::NOISE_MAX) begin
                  rsp_data_in = gn3_pkg::NOISE_MAX[gn3_pkg::NOISE_W-1:0];
               end else if (fin < gn3_pkg::NOISE_MIN) begin
                  rsp_data_in = gn3_pkg::NOISE_MIN[gn3_pkg::NOISE_W-1:0];
               end else begin
                  rsp_data_in = fin[gn3_pkg::NOISE_W-1:0];
               end
               state_in = gn3_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gn3_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule

FILE: hw/rtl/gn3_check.sv
// ----------------------------------------------------------------------------
// Gradient noise port checker
// Watches the request and response ports of the evaluator over time.
// ----------------------------------------------------------------------------
module gn3_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [23:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == gn3_pkg::OP_EVAL) |=> !req_tready)
      else $error("request taken while an evaluation runs");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:19] == 5'd0))
      else $error("response padding bits set");

endmodule

bind gradient_noise_3d_eval gn3_check u_gn3_check (.*);

FILE: tb/gradient_noise_3d_eval_tb.sv
// ----------------------------------------------------------------------------
// Gradient noise evaluator testbench
// Loads the entropy table with flat and random contents, then evaluates
// points across the whole Q16.16 range while both stream sides idle at
// random. Each response is compared with a built-in fixed-point predictor of
// the noise value.
// ----------------------------------------------------------------------------
module gradient_noise_3d_eval_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        op;
      logic [7:0]  idx;
      logic [7:0]  val;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
   } noise_req_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;

   noise_req_type               pending_req[$];
   noise_req_type               cur_req;
   logic [gn3_pkg::NOISE_W-1:0] expected_noise[$];
   logic [7:0]                  noise_table[gn3_pkg::TABLE_SIZE];
   int                          errors = 0;
   int                          send_gap = 0;
   int                          recv_hold = 0;
   int                          rsp_count = 0;
   bit                          long_hold_done = 1'b0;
   bit                          quiet = 1'b0;

   gradient_noise_3d_eval i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic longint round_shift16(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n = n - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] hash_word(logic [31:0] a);
      logic [7:0] off;
      off = a[7:0] - 8'd4;
      return {noise_table[8'(off + 3)], noise_table[8'(off + 2)],
              noise_table[8'(off + 1)], noise_table[off]};
   endfunction

   function automatic longint gradient_dot(logic [2:0][31:0] c, longint dx, longint dy,
                                           longint dz);
      logic [2:0][31:0] a;
      logic [31:0]      t;
      longint           v[3];
      longint           d[3];
      longint           n;
      longint           acc;
      longint           u;
      longint unsigned  r;
      longint unsigned  mag;
      longint unsigned  q;
      a = c;
      d[0] = dx;
      d[1] = dy;
      d[2] = dz;
      n = 0;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = a[i] * hash_word(a[i]);
         t = {a[i][15:0], a[i][31:16]};
         a[(i + 1) % 3] = a[(i + 1) % 3] ^ t;
      end
      for (int i = 0; i < 3; i++) begin
         v[i] = longint'($signed(noise_table[a[i][7:0]]));
         n += v[i] * v[i];
      end
      if (n == 0) return 0;
      r = int_sqrt(longint'(n) << 32);
      for (int i = 0; i < 3; i++) begin
         mag = (v[i] < 0 ? -v[i] : v[i]) << 32;
         q = (mag + r / 2) / r;
         if (q > 65536) q = 65536;
         u = v[i] < 0 ? -longint'(q) : longint'(q);
         acc += u * d[i];
      end
      return round_shift16(acc);
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      return round_shift16(a * (65536 - w) + b * w);
   endfunction

   function automatic logic [gn3_pkg::NOISE_W-1:0] predict_noise(noise_req_type it);
      logic [2:0][31:0] pt;
      logic [2:0][31:0] base;
      logic [2:0][31:0] c;
      longint           w[3];
      longint           d[3];
      longint           s[8];
      longint           ya;
      longint           yb;
      longint           res;
      pt[0] = it.px;
      pt[1] = it.py;
      pt[2] = it.pz;
      for (int k = 0; k < 3; k++) begin
         base[k] = {{16{pt[k][31]}}, pt[k][31:16]};
         w[k] = longint'(pt[k][15:0]);
      end
      for (int ci = 0; ci < 8; ci++) begin
         for (int k = 0; k < 3; k++) begin
            if (ci[2 - k]) begin
               c[k] = base[k] + 32'd1;
               d[k] = 65536 - w[k];
            end else begin
               c[k] = base[k];
               d[k] = -w[k];
            end
         end
         s[ci] = gradient_dot(c, d[0], d[1], d[2]);
      end
      ya = blend(blend(s[0], s[1], w[2]), blend(s[2], s[3], w[2]), w[1]);
      yb = blend(blend(s[4], s[5], w[2]), blend(s[6], s[7], w[2]), w[1]);
      res = blend(ya, yb, w[0]);
      if (res > 131072) res = 131072;
      if (res < -131072) res = -131072;
      return res[gn3_pkg::NOISE_W-1:0];
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (quiet || roll < 12) return 0;
      if (roll < 18) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_req.op == gn3_pkg::OP_WRITE) begin
               noise_table[cur_req.idx] = cur_req.val;
            end else begin
               expected_noise.push_back(predict_noise(cur_req));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               cur_req = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_req.op;
               req_tdata <= {cur_req.pz, cur_req.py, cur_req.px, cur_req.val, cur_req.idx};
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_noise.size() == 0) begin
               $display("%0t: unexpected response, actual noise_value %0d", $time,
                        $signed(rsp_tdata[gn3_pkg::NOISE_W-1:0]));
               errors++;
            end else if (rsp_tdata[gn3_pkg::NOISE_W-1:0] !== expected_noise[0]) begin
               $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time,
                        $signed(expected_noise[0]),
                        $signed(rsp_tdata[gn3_pkg::NOISE_W-1:0]));
               errors++;
               void'(expected_noise.pop_front());
            end else begin
               void'(expected_noise.pop_front());
            end
            if (rsp_count == 40 && !long_hold_done) begin
               long_hold_done = 1'b1;
               recv_hold = 5000;
            end else begin
               recv_hold = pick_gap();
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_write(logic [7:0] idx, logic [7:0] val);
      noise_req_type it;
      it = '{gn3_pkg::OP_WRITE, idx, val, 32'($urandom), 32'($urandom), 32'($urandom)};
      pending_req.push_back(it);
   endtask

   task automatic push_eval(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      noise_req_type it;
      it = '{gn3_pkg::OP_EVAL, 8'($urandom), 8'($urandom), px, py, pz};
      pending_req.push_back(it);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 32'($urandom);
         1: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
         2: return 32'h8000_0000 + 32'($urandom_range(0, 32'h0003_FFFF));
         3: return 32'h7FFF_FFFF - 32'($urandom_range(0, 32'h0003_FFFF));
         default: return {16'($urandom), 16'($urandom_range(0, 3) * 16'h5555)};
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_req.size() > 0 || req_tvalid || expected_noise.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic fill_table(int mode);
      for (int i = 0; i < gn3_pkg::TABLE_SIZE; i++) begin
         case (mode)
            0: push_write(8'(i), 8'h00);
            1: push_write(8'(i), 8'h80);
            2: push_write(8'(i), 8'h7F);
            default: push_write(8'(i), 8'($urandom));
         endcase
      end
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 4) push_write(8'($urandom), 8'($urandom));
         else push_eval(rand_coord(), rand_coord(), rand_coord());
      end
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Flat zero table: every gradient is zero, so the noise must be zero.
      fill_table(0);
      push_eval(32'h0000_8000, 32'h0001_0000, 32'hFFFF_FFFF);
      push_eval(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      wait_drained();
      fill_table(3);
      push_eval(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
      push_eval(32'h7FFF_FFFF, 32'h0000_8000, 32'h0001_0001);
      push_eval(32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_0000);
      wait_drained();
      random_phase(120);
      quiet = 1'b1;
      random_phase(50);
      quiet = 1'b0;
      random_phase(110);
      repeat (2000) @(posedge clock);
      if (errors == 0 && expected_noise.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/gn3_pkg.sv
hw/rtl/gn3_norm.sv
hw/rtl/gradient_noise_3d_eval.sv
hw/rtl/gn3_check.sv
tb/gradient_noise_3d_eval_tb.sv
